@@ rtl/lsc_pkg.sv @@
// Shared widths, register indexes and the side-data word for the level-set
// contour pixel update pipeline. No dependencies.
package lsc_pkg;

  localparam int VALUE_BITS    = 32;
  localparam int FRACTION_BITS = 16;
  localparam int WEIGHT_BITS   = 17;
  localparam int SLOPE_BITS    = 18;
  localparam int TAU_BITS      = 32;
  localparam int BIAS_BITS     = 16;
  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 32;

  // first differences, second differences
  localparam int D1W  = VALUE_BITS + 1;
  localparam int D2W  = VALUE_BITS + 2;
  // square / cross product of first differences, and its split point
  localparam int SQW  = 2 * D1W;
  localparam int HALF = D1W;
  // partial product of a second difference by half of a square
  localparam int PPW  = D2W + HALF + 1;
  // curvature numerator, denominator, doubled denominator
  localparam int NW   = SQW + D2W + 4;
  localparam int DENW = SQW + 1;
  localparam int DVW  = DENW + 1;
  // quotient bits of the curvature and its signed form
  localparam int QW   = VALUE_BITS + 5;
  localparam int KW   = QW + 1;
  // front term, weighted sum and its split for the step multiply
  localparam int FW   = D1W;
  localparam int GW   = SLOPE_BITS + FW + 1;
  localparam int WKW  = WEIGHT_BITS + 1 + KW;
  localparam int SW   = WKW + 1;
  localparam int MLO  = (SW + 1) / 2;
  localparam int MHI  = SW - MLO;
  localparam int UW   = TAU_BITS + SW + 1;
  localparam int RW   = 64;
  localparam int LIMIT_EXP = RW - 2;

  localparam int LATENCY = 5 + QW + 7;

  localparam logic [RW-1:0] UPDATE_LIMIT = RW'(1) << LIMIT_EXP;
  localparam logic [TAU_BITS-1:0]  STEP_SCALE_RESET = TAU_BITS'(65536);
  localparam logic [BIAS_BITS-1:0] DENOM_BIAS_RESET = BIAS_BITS'(66);

  localparam logic signed [RW-1:0] RES_MAX = RW'((64'd1 << (VALUE_BITS - 1)) - 64'd1);
  localparam logic signed [RW-1:0] RES_MIN = -RES_MAX - RW'(1);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_STEP_SCALE = 8'd0,
    REG_DENOM_BIAS = 8'd1
  } reg_index_t;

  // what rides alongside the divider
  typedef struct packed {
    logic signed [VALUE_BITS-1:0] c;
    logic [WEIGHT_BITS-1:0]       w;
    logic signed [GW-1:0]         g;
    logic                         neg;
    logic                         dzero;
  } side_t;

endpackage

@@ rtl/lsc_div.sv @@
// Pipelined restoring divider for the curvature quotient, one quotient bit
// per stage. Depends on lsc_pkg.
module lsc_div import lsc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [DVW-1:0]   in_rem,
  input  logic [QW-1:0]    in_low,
  input  logic [DVW-1:0]   in_den,
  input  side_t            in_side,
  output logic             out_valid,
  output logic [QW-1:0]    out_q,
  output side_t            out_side
);

  logic             vld  [QW];
  logic [DVW-1:0]   rem  [QW];
  logic [QW-1:0]    low  [QW];
  logic [DVW-1:0]   den  [QW];
  logic [QW-1:0]    quo  [QW];
  side_t            side [QW];

  for (genvar gi = 0; gi < QW; gi++) begin : g_stage
    logic             vld_in;
    logic [DVW-1:0]   rem_in;
    logic [QW-1:0]    low_in;
    logic [DVW-1:0]   den_in;
    logic [QW-1:0]    quo_in;
    side_t            side_in;
    logic [DVW:0]     trial;
    logic             fits;

    if (gi == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rem_in  = in_rem;
      assign low_in  = in_low;
      assign den_in  = in_den;
      assign quo_in  = '0;
      assign side_in = in_side;
    end else begin : g_rest
      assign vld_in  = vld[gi-1];
      assign rem_in  = rem[gi-1];
      assign low_in  = low[gi-1];
      assign den_in  = den[gi-1];
      assign quo_in  = quo[gi-1];
      assign side_in = side[gi-1];
    end

    // bring down the next numerator bit, subtract when it fits
    assign trial = {rem_in, low_in[QW-1-gi]};
    assign fits  = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[gi] <= 1'b0;
      end else begin
        vld[gi] <= vld_in;
      end
      rem[gi]  <= fits ? DVW'(trial - {1'b0, den_in}) : DVW'(trial);
      low[gi]  <= low_in;
      den[gi]  <= den_in;
      quo[gi]  <= quo_in | (fits ? (QW'(1) << (QW - 1 - gi)) : '0);
      side[gi] <= side_in;
    end
  end

  assign out_valid = vld[QW-1];
  assign out_q     = quo[QW-1];
  assign out_side  = side[QW-1];

endmodule

@@ rtl/level_set_contour_pixel_update_core.sv @@
// Top level of the level-set contour pixel update pipeline.
// Depends on lsc_pkg and lsc_div.
//
// Usage:
//  - Input: drive the 3x3 phi neighborhood, edge_weight and the two weight
//    slopes with start high; the word is taken at the edge where start is
//    high and busy is low. busy is high only during reset, so one word can
//    enter every cycle.
//  - Output: done pulses for one cycle with phi_next and saturated. The
//    receiver cannot hold results off; every result shows exactly once.
//  - Pipeline: 5 front stages, 37 divider stages and 7 back stages between
//    accept and done. Throughput: one pixel per cycle.
//  - The curvature quotient is produced by a 37-stage restoring divider,
//    one quotient bit per stage, which sets the depth.
//  - Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0
//    is the step scale, index 1 the denominator bias, others are dropped.
//    cfg_ready is always high. Write only while the pipe is empty.
//  - Reset (rst, synchronous): clear all valid bits, restore the step scale
//    to 1.0 and the bias to 66.
module level_set_contour_pixel_update_core import lsc_pkg::*; (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [VALUE_BITS-1:0]    phi_top_left,
  input  logic signed [VALUE_BITS-1:0]    phi_top,
  input  logic signed [VALUE_BITS-1:0]    phi_top_right,
  input  logic signed [VALUE_BITS-1:0]    phi_left,
  input  logic signed [VALUE_BITS-1:0]    phi_center,
  input  logic signed [VALUE_BITS-1:0]    phi_right,
  input  logic signed [VALUE_BITS-1:0]    phi_bottom_left,
  input  logic signed [VALUE_BITS-1:0]    phi_bottom,
  input  logic signed [VALUE_BITS-1:0]    phi_bottom_right,
  input  logic [WEIGHT_BITS-1:0]          edge_weight,
  input  logic signed [SLOPE_BITS-1:0]    weight_slope_x,
  input  logic signed [SLOPE_BITS-1:0]    weight_slope_y,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]       cfg_index,
  input  logic [CFG_DATA_BITS-1:0]       cfg_data,
  output logic                            done,
  output logic signed [VALUE_BITS-1:0]    phi_next,
  output logic                            saturated
);

  // configuration registers
  logic [TAU_BITS-1:0]  step_scale;
  logic [BIAS_BITS-1:0] denominator_bias;

  assign cfg_ready = 1'b1;
  assign busy      = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_scale       <= STEP_SCALE_RESET;
      denominator_bias <= DENOM_BIAS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_STEP_SCALE) begin
        step_scale <= TAU_BITS'(cfg_data);
      end else if (cfg_index == REG_DENOM_BIAS) begin
        denominator_bias <= cfg_data[BIAS_BITS-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: differences and upwind selection
  // ---------------------------------------------------------------------
  logic                          v1;
  logic signed [D1W-1:0]         s1_dx, s1_dy, s1_fx, s1_fy;
  logic signed [D2W-1:0]         s1_dxx, s1_dyy, s1_dxy;
  logic signed [VALUE_BITS-1:0]  s1_c;
  logic [WEIGHT_BITS-1:0]        s1_w;
  logic signed [SLOPE_BITS-1:0]  s1_wx, s1_wy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
    s1_dx  <= D1W'(phi_right) - D1W'(phi_left);
    s1_dy  <= D1W'(phi_bottom) - D1W'(phi_top);
    s1_dxx <= D2W'(phi_right) + D2W'(phi_left) - (D2W'(phi_center) <<< 1);
    s1_dyy <= D2W'(phi_bottom) + D2W'(phi_top) - (D2W'(phi_center) <<< 1);
    s1_dxy <= D2W'(phi_top_left) + D2W'(phi_bottom_right)
              - D2W'(phi_top_right) - D2W'(phi_bottom_left);
    // forward difference where the slope is positive, backward otherwise
    s1_fx  <= (weight_slope_x > 0) ? D1W'(phi_right) - D1W'(phi_center)
                                   : D1W'(phi_center) - D1W'(phi_left);
    s1_fy  <= (weight_slope_y > 0) ? D1W'(phi_bottom) - D1W'(phi_center)
                                   : D1W'(phi_center) - D1W'(phi_top);
    s1_c   <= phi_center;
    s1_w   <= edge_weight;
    s1_wx  <= weight_slope_x;
    s1_wy  <= weight_slope_y;
  end

  // ---------------------------------------------------------------------
  // Stage 2: squares, cross product, front products
  // ---------------------------------------------------------------------
  logic                          v2;
  logic signed [SQW-1:0]         s2_dx2, s2_dy2, s2_dxdy;
  logic signed [D2W-1:0]         s2_dxx, s2_dyy, s2_dxy;
  logic signed [GW-2:0]          s2_gx, s2_gy;
  logic signed [VALUE_BITS-1:0]  s2_c;
  logic [WEIGHT_BITS-1:0]        s2_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    s2_dx2  <= s1_dx * s1_dx;
    s2_dy2  <= s1_dy * s1_dy;
    s2_dxdy <= s1_dx * s1_dy;
    s2_gx   <= s1_wx * s1_fx;
    s2_gy   <= s1_wy * s1_fy;
    s2_dxx  <= s1_dxx;
    s2_dyy  <= s1_dyy;
    s2_dxy  <= s1_dxy;
    s2_c    <= s1_c;
    s2_w    <= s1_w;
  end

  // ---------------------------------------------------------------------
  // Stage 3: numerator partial products, denominator, front sum
  // ---------------------------------------------------------------------
  logic                          v3;
  logic signed [PPW-1:0]         s3_alo, s3_ahi, s3_blo, s3_bhi, s3_xlo, s3_xhi;
  logic [DENW-1:0]               s3_den;
  logic signed [GW-1:0]          s3_g;
  logic signed [VALUE_BITS-1:0]  s3_c;
  logic [WEIGHT_BITS-1:0]        s3_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    s3_alo <= s2_dxx * $signed({1'b0, s2_dy2[HALF-1:0]});
    s3_ahi <= s2_dxx * $signed({1'b0, s2_dy2[SQW-1:HALF]});
    s3_blo <= s2_dyy * $signed({1'b0, s2_dx2[HALF-1:0]});
    s3_bhi <= s2_dyy * $signed({1'b0, s2_dx2[SQW-1:HALF]});
    s3_xlo <= s2_dxy * $signed({1'b0, s2_dxdy[HALF-1:0]});
    s3_xhi <= s2_dxy * $signed(s2_dxdy[SQW-1:HALF]);
    s3_den <= DENW'($unsigned(s2_dx2)) + DENW'($unsigned(s2_dy2))
              + (DENW'(denominator_bias) << (FRACTION_BITS + 2));
    s3_g   <= GW'(s2_gx) + GW'(s2_gy);
    s3_c   <= s2_c;
    s3_w   <= s2_w;
  end

  // ---------------------------------------------------------------------
  // Stage 4: assemble the numerator
  // ---------------------------------------------------------------------
  logic                          v4;
  logic signed [NW-1:0]          s4_n;
  logic [DVW-1:0]                s4_den2;
  logic                          s4_dzero;
  logic signed [GW-1:0]          s4_g;
  logic signed [VALUE_BITS-1:0]  s4_c;
  logic [WEIGHT_BITS-1:0]        s4_w;
  logic signed [NW-1:0]          ta, tb, tx;

  always_comb begin
    ta = (NW'(s3_ahi) <<< HALF) + NW'(s3_alo);
    tb = (NW'(s3_bhi) <<< HALF) + NW'(s3_blo);
    tx = (NW'(s3_xhi) <<< HALF) + NW'(s3_xlo);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    s4_n     <= (ta <<< 1) - tx + (tb <<< 1);
    s4_den2  <= {s3_den, 1'b0};
    s4_dzero <= (s3_den == '0);
    s4_g     <= s3_g;
    s4_c     <= s3_c;
    s4_w     <= s3_w;
  end

  // ---------------------------------------------------------------------
  // Stage 5: numerator magnitude, split into divider start and low bits
  // ---------------------------------------------------------------------
  logic                          v5;
  logic [DVW-1:0]                s5_rem;
  logic [QW-1:0]                 s5_low;
  logic [DVW-1:0]                s5_den2;
  side_t                         s5_side;
  logic [NW-1:0]                 nmag;

  assign nmag = s4_n[NW-1] ? NW'(-s4_n) : NW'(s4_n);

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    s5_rem        <= DVW'(nmag >> QW);
    s5_low        <= nmag[QW-1:0];
    s5_den2       <= s4_den2;
    s5_side.c     <= s4_c;
    s5_side.w     <= s4_w;
    s5_side.g     <= s4_g;
    s5_side.neg   <= s4_n[NW-1];
    s5_side.dzero <= s4_dzero;
  end

  // ---------------------------------------------------------------------
  // Divider: curvature magnitude, truncated
  // ---------------------------------------------------------------------
  logic                          dv_valid;
  logic [QW-1:0]                 dv_q;
  side_t                         dv_side;

  lsc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v5),
    .in_rem    (s5_rem),
    .in_low    (s5_low),
    .in_den    (s5_den2),
    .in_side   (s5_side),
    .out_valid (dv_valid),
    .out_q     (dv_q),
    .out_side  (dv_side)
  );

  // ---------------------------------------------------------------------
  // Stage 6: signed curvature; a zero denominator means flat, curvature 0
  // ---------------------------------------------------------------------
  logic                          v6;
  logic signed [KW-1:0]          s6_k;
  logic [WEIGHT_BITS-1:0]        s6_w;
  logic signed [GW-1:0]          s6_g;
  logic signed [VALUE_BITS-1:0]  s6_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= dv_valid;
    end
    if (dv_side.dzero) begin
      s6_k <= '0;
    end else if (dv_side.neg) begin
      s6_k <= -$signed({1'b0, dv_q});
    end else begin
      s6_k <= $signed({1'b0, dv_q});
    end
    s6_w <= dv_side.w;
    s6_g <= dv_side.g;
    s6_c <= dv_side.c;
  end

  // Stage 7: weight times curvature
  logic                          v7;
  logic signed [WKW-1:0]         s7_wk;
  logic signed [GW-1:0]          s7_g;
  logic signed [VALUE_BITS-1:0]  s7_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= v6;
    end
    s7_wk <= $signed({1'b0, s6_w}) * s6_k;
    s7_g  <= s6_g;
    s7_c  <= s6_c;
  end

  // Stage 8: add the front term
  logic                          v8;
  logic signed [SW-1:0]          s8_s;
  logic signed [VALUE_BITS-1:0]  s8_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else begin
      v8 <= v7;
    end
    s8_s <= SW'(s7_wk) + SW'(s7_g);
    s8_c <= s7_c;
  end

  // Stage 9: sign and magnitude of the sum
  logic                          v9;
  logic                          s9_neg;
  logic [SW-1:0]                 s9_mag;
  logic signed [VALUE_BITS-1:0]  s9_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else begin
      v9 <= v8;
    end
    s9_neg <= s8_s[SW-1];
    s9_mag <= s8_s[SW-1] ? SW'(-s8_s) : SW'(s8_s);
    s9_c   <= s8_c;
  end

  // Stage 10: step scale times magnitude, two partial products
  logic                          v10;
  logic [TAU_BITS+MLO-1:0]       s10_plo;
  logic [TAU_BITS+MHI-1:0]       s10_phi;
  logic                          s10_neg;
  logic signed [VALUE_BITS-1:0]  s10_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v10 <= 1'b0;
    end else begin
      v10 <= v9;
    end
    s10_plo <= (TAU_BITS+MLO)'(step_scale) * (TAU_BITS+MLO)'(s9_mag[MLO-1:0]);
    s10_phi <= (TAU_BITS+MHI)'(step_scale) * (TAU_BITS+MHI)'(s9_mag[SW-1:MLO]);
    s10_neg <= s9_neg;
    s10_c   <= s9_c;
  end

  // Stage 11: combine, drop the fraction, clamp huge updates
  logic                          v11;
  logic [RW-1:0]                 s11_umag;
  logic                          s11_neg;
  logic signed [VALUE_BITS-1:0]  s11_c;
  logic [UW-1:0]                 ufull, ushift;

  always_comb begin
    ufull  = (UW'(s10_phi) << MLO) + UW'(s10_plo);
    ushift = ufull >> (2 * FRACTION_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v11 <= 1'b0;
    end else begin
      v11 <= v10;
    end
    s11_umag <= (ushift > UW'(UPDATE_LIMIT)) ? UPDATE_LIMIT : ushift[RW-1:0];
    s11_neg  <= s10_neg;
    s11_c    <= s10_c;
  end

  // Stage 12: apply the update, saturate, present the result
  logic signed [RW-1:0]          res;

  assign res = s11_neg ? RW'(s11_c) - $signed(s11_umag)
                       : RW'(s11_c) + $signed(s11_umag);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v11;
    end
    if (res > RES_MAX) begin
      phi_next  <= VALUE_BITS'(RES_MAX);
      saturated <= 1'b1;
    end else if (res < RES_MIN) begin
      phi_next  <= VALUE_BITS'(RES_MIN);
      saturated <= 1'b1;
    end else begin
      phi_next  <= res[VALUE_BITS-1:0];
      saturated <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  // every accepted word comes out exactly after the pipeline depth
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted word did not complete after pipeline depth");

  // a clamped result sits on a range limit
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    (done && saturated) |->
      (phi_next == VALUE_BITS'(RES_MAX) || phi_next == VALUE_BITS'(RES_MIN)))
    else $error("saturated result not at range limit");

  // no result without a word accepted the pipeline depth earlier
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    (!start || busy) |-> ##LATENCY !done)
    else $error("result without an accepted word");
`endif

endmodule

@@ verif/level_set_contour_pixel_update_core_tb.sv @@
// Self-checking testbench for level_set_contour_pixel_update_core: a directed
// table, then random neighborhoods, checked against an in-bench update model.
// Depends on lsc_pkg and the RTL of the core only.
`timescale 1ns / 1ps

module level_set_contour_pixel_update_core_tb;
  import lsc_pkg::*;

  typedef logic signed [127:0] wide_t;

  // one pixel word: phi[0..8] is top-left .. bottom-right in raster order
  typedef struct {
    logic signed [VALUE_BITS-1:0] phi [9];
    logic [WEIGHT_BITS-1:0]       w;
    logic signed [SLOPE_BITS-1:0] sx;
    logic signed [SLOPE_BITS-1:0] sy;
  } pixel_t;

  typedef struct {
    logic signed [VALUE_BITS-1:0] phi;
    logic                         sat;
  } update_t;

  // directed row: known = 1 when the expected update is typed in by hand
  typedef struct {
    pixel_t  pix;
    logic    known;
    update_t want;
  } row_t;

  localparam logic [CFG_INDEX_BITS-1:0] REG_UNMAPPED = 8'd7;
  localparam int GAP_MAX       = 5;
  localparam int STALL_LIMIT   = 2000;
  localparam int PHASE_ITEMS   = 210;
  localparam logic signed [VALUE_BITS-1:0] PMAX = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_BITS-1:0] PMIN = 32'sh8000_0000;
  localparam logic [WEIGHT_BITS-1:0] W_ONE = 17'd65536;

  logic clk, rst, start, busy;
  logic cfg_valid, cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;
  logic done, saturated;
  logic signed [VALUE_BITS-1:0] phi_next;

  pixel_t  cur;          // word on the input ports
  logic    cur_known;    // hand-typed expectation rides with the word
  update_t cur_want;

  logic [TAU_BITS-1:0]  tau_copy;
  logic [BIAS_BITS-1:0] bias_copy;
  update_t pending_updates [$];
  int  idle_cycles;
  bit  failed;

  level_set_contour_pixel_update_core dut (
    .clk, .rst, .start, .busy,
    .phi_top_left(cur.phi[0]), .phi_top(cur.phi[1]), .phi_top_right(cur.phi[2]),
    .phi_left(cur.phi[3]), .phi_center(cur.phi[4]), .phi_right(cur.phi[5]),
    .phi_bottom_left(cur.phi[6]), .phi_bottom(cur.phi[7]),
    .phi_bottom_right(cur.phi[8]),
    .edge_weight(cur.w), .weight_slope_x(cur.sx), .weight_slope_y(cur.sy),
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .done, .phi_next, .saturated
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Explicit geodesic update in exact wide arithmetic; 128 bits hold every
  // intermediate (the numerator needs about 104), so no rounding sneaks in
  // except the two truncations the block itself does.
  function automatic update_t contour_update(pixel_t p, logic [TAU_BITS-1:0] tau,
                                             logic [BIAS_BITS-1:0] bias);
    wide_t tl, t, tr, l, c, r, bl, b, br, w, sx, sy;
    wide_t dx, dy, dxx, dyy, dxy, num, den, k, g, s, smag, u;
    update_t o;
    tl = wide_t'(p.phi[0]); t = wide_t'(p.phi[1]); tr = wide_t'(p.phi[2]);
    l = wide_t'(p.phi[3]); c = wide_t'(p.phi[4]); r = wide_t'(p.phi[5]);
    bl = wide_t'(p.phi[6]); b = wide_t'(p.phi[7]); br = wide_t'(p.phi[8]);
    w = wide_t'(p.w);
    sx = wide_t'(p.sx); sy = wide_t'(p.sy);
    dx = r - l; dy = b - t;
    dxx = r + l - 2 * c; dyy = b + t - 2 * c;
    dxy = tl + br - tr - bl;
    num = 2 * dxx * dy * dy - dx * dy * dxy + 2 * dyy * dx * dx;
    den = dx * dx + dy * dy + (wide_t'(bias) << (FRACTION_BITS + 2));
    // flat patch with zero bias: curvature is taken as zero
    k = (den == 0) ? wide_t'(0) : num / (2 * den);
    g = ((sx > 0) ? sx * (r - c) : sx * (c - l))
      + ((sy > 0) ? sy * (b - c) : sy * (c - t));
    s = w * k + g;
    smag = (s < 0) ? -s : s;
    u = (wide_t'(tau) * smag) >>> (2 * FRACTION_BITS);
    if (u > (wide_t'(1) << LIMIT_EXP)) u = wide_t'(1) << LIMIT_EXP;
    u = (s < 0) ? c - u : c + u;
    o.sat = 1'b1;
    if (u > wide_t'(PMAX)) o.phi = PMAX;
    else if (u < wide_t'(PMIN)) o.phi = PMIN;
    else begin
      o.phi = u[VALUE_BITS-1:0];
      o.sat = 1'b0;
    end
    return o;
  endfunction

  // Track config writes, predict on every accepted word, check every done.
  always @(posedge clk) begin
    update_t want;
    logic    active;
    if (!rst) begin
      active = (cfg_valid && cfg_ready) || (start && !busy) || done;
      idle_cycles <= active ? 0 : idle_cycles + 1;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_STEP_SCALE) tau_copy <= cfg_data[TAU_BITS-1:0];
        else if (cfg_index == REG_DENOM_BIAS) bias_copy <= cfg_data[BIAS_BITS-1:0];
      end
      if (start && !busy) begin
        pending_updates.push_back(cur_known ? cur_want
                                            : contour_update(cur, tau_copy, bias_copy));
      end
      if (done) begin
        if (pending_updates.size() == 0) begin
          $display("%0t: unexpected result phi_next=%h saturated=%b",
                   $time, phi_next, saturated);
          failed = 1'b1;
        end else begin
          want = pending_updates.pop_front();
          if (phi_next !== want.phi) begin
            $display("%0t: phi_next expected %h actual %h", $time, want.phi, phi_next);
            failed = 1'b1;
          end
          if (saturated !== want.sat) begin
            $display("%0t: saturated expected %b actual %b", $time, want.sat, saturated);
            failed = 1'b1;
          end
        end
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("level_set_contour_pixel_update_core_tb NOT OK");
        $finish;
      end
    end
  end

  // Hold start high across back-to-back words; drop it only for a real gap.
  task automatic send_pixel(pixel_t p, logic known, update_t want);
    int gap;
    gap = $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cur <= p;
    cur_known <= known;
    cur_want <= want;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Let the pipe drain before touching a register.
  task automatic drain_pipe();
    start <= 1'b0;
    @(posedge clk);
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [VALUE_BITS-1:0] rand_value();
    return $urandom();
  endfunction

  // Mostly smooth patches around a random center (the region where the
  // curvature term matters), plus full-range noise and occasional full-range weights and slopes.
  function automatic pixel_t rand_pixel();
    pixel_t p;
    int mode, spread;
    logic signed [VALUE_BITS-1:0] base;
    mode = $urandom_range(0, 9);
    spread = 1 << $urandom_range(0, 20);
    base = (mode == 9) ? (($urandom_range(0, 1) != 0) ? PMAX : PMIN) : rand_value();
    for (int i = 0; i < 9; i++) begin
      if (mode >= 7) p.phi[i] = rand_value();
      else p.phi[i] = base + $signed($urandom_range(0, 2 * spread)) - spread;
    end
    if ($urandom_range(0, 15) == 0) begin
      p.w = WEIGHT_BITS'($urandom());
      p.sx = SLOPE_BITS'($urandom());
      p.sy = SLOPE_BITS'($urandom());
    end else begin
      p.w = WEIGHT_BITS'($urandom_range(0, 65536));
      p.sx = SLOPE_BITS'($signed($urandom_range(0, 131072)) - 65536);
      p.sy = SLOPE_BITS'($signed($urandom_range(0, 131072)) - 65536);
    end
    return p;
  endfunction

  function automatic pixel_t flat_pixel(logic signed [VALUE_BITS-1:0] v,
                                        logic [WEIGHT_BITS-1:0] w);
    pixel_t p;
    foreach (p.phi[i]) p.phi[i] = v;
    p.w = w;
    p.sx = '0;
    p.sy = '0;
    return p;
  endfunction

  function automatic row_t mk_row(pixel_t p, logic known,
                                  logic signed [VALUE_BITS-1:0] phi, logic sat);
    row_t r;
    r.pix = p;
    r.known = known;
    r.want.phi = phi;
    r.want.sat = sat;
    return r;
  endfunction

  row_t directed [$];
  update_t none;

  initial begin
    pixel_t p;
    failed = 1'b0;
    idle_cycles = 0;
    none = '{phi: '0, sat: 1'b0};
    tau_copy = STEP_SCALE_RESET;
    bias_copy = DENOM_BIAS_RESET;
    rst <= 1'b1;
    start <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    cur <= flat_pixel('0, '0);
    cur_known <= 1'b0;
    cur_want <= none;

    // Flat patches leave phi untouched; the rest go through the model.
    directed.push_back(mk_row(flat_pixel('0, '0), 1'b1, '0, 1'b0));
    directed.push_back(mk_row(flat_pixel(PMAX, W_ONE), 1'b1, PMAX, 1'b0));
    directed.push_back(mk_row(flat_pixel(PMIN, W_ONE), 1'b1, PMIN, 1'b0));
    directed.push_back(mk_row(flat_pixel(32'sh0001_0000, 17'h1FFFF), 1'b1,
                              32'sh0001_0000, 1'b0));
    // steepest ramps with full-scale slopes, both signs
    p = flat_pixel(PMIN, W_ONE);
    p.phi[5] = PMAX; p.phi[7] = PMAX; p.sx = 18'sd65536; p.sy = 18'sd65536;
    directed.push_back(mk_row(p, 1'b0, '0, 1'b0));
    p.sx = -18'sd65536; p.sy = -18'sd65536;
    directed.push_back(mk_row(p, 1'b0, '0, 1'b0));
    p = flat_pixel(PMAX, 17'h1FFFF);
    p.phi[3] = PMIN; p.phi[1] = PMIN; p.sx = 18'sh1FFFF; p.sy = 18'sh20000;
    directed.push_back(mk_row(p, 1'b0, '0, 1'b0));
    // checkerboard of extremes: largest curvature numerator
    p = flat_pixel(PMIN, W_ONE);
    p.phi[0] = PMAX; p.phi[2] = PMAX; p.phi[4] = PMAX; p.phi[6] = PMAX; p.phi[8] = PMAX;
    directed.push_back(mk_row(p, 1'b0, '0, 1'b0));
    p.phi[4] = PMIN; p.phi[5] = PMAX; p.phi[7] = PMAX;
    directed.push_back(mk_row(p, 1'b0, '0, 1'b0));
    // saddle and bump shapes of moderate size
    p = flat_pixel(32'sh0000_8000, W_ONE);
    p.phi[1] = 32'sh0002_0000; p.phi[7] = 32'sh0003_0000;
    p.phi[3] = -32'sh0001_0000; p.phi[0] = 32'sh0000_4000;
    directed.push_back(mk_row(p, 1'b0, '0, 1'b0));
    for (int i = 0; i < 6; i++) directed.push_back(mk_row(rand_pixel(), 1'b0, '0, 1'b0));

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_pixel(directed[i].pix, directed[i].known, directed[i].want);

    // Phases over register settings; the sender waits for an empty pipe
    // before each one, and unmapped writes must be dropped.
    for (int ph = 0; ph < 5; ph++) begin
      drain_pipe();
      case (ph)
        0: begin
          write_reg(REG_STEP_SCALE, 32'hFFFF_FFFF);
          write_reg(REG_DENOM_BIAS, 32'h0000_0001);
        end
        1: begin
          write_reg(REG_STEP_SCALE, 32'h0000_0000);
          write_reg(REG_DENOM_BIAS, 32'hFFFF_FFFF);
        end
        2: begin
          // zero bias: flat patches must not divide by zero
          write_reg(REG_STEP_SCALE, 32'h0000_4000);
          write_reg(REG_DENOM_BIAS, 32'h0000_0000);
          write_reg(REG_UNMAPPED, 32'h1234_5678);
        end
        3: begin
          write_reg(REG_STEP_SCALE, $urandom());
          write_reg(REG_DENOM_BIAS, $urandom_range(1, 65535));
        end
        default: begin
          write_reg(REG_STEP_SCALE, CFG_DATA_BITS'(STEP_SCALE_RESET));
          write_reg(REG_DENOM_BIAS, CFG_DATA_BITS'(DENOM_BIAS_RESET));
          write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
        end
      endcase
      if (ph == 2) begin
        p = flat_pixel(32'sh0123_4567, W_ONE);
        send_pixel(p, 1'b1, '{phi: 32'sh0123_4567, sat: 1'b0});
        p.sx = 18'sd1000;
        send_pixel(p, 1'b0, none);
      end
      for (int n = 0; n < PHASE_ITEMS; n++) send_pixel(rand_pixel(), 1'b0, none);
    end

    drain_pipe();
    if (!failed) begin
      $display("level_set_contour_pixel_update_core_tb OK");
    end else begin
      $display("level_set_contour_pixel_update_core_tb NOT OK");
    end
    $finish;
  end

endmodule
